// File: hdl/kfls_pkg.sv
// ============================================================================
// kfls_pkg
// Shared types and constants of the keyframe linear sampler.
// ============================================================================
`default_nettype none

package kfls_pkg;

  // Key table geometry
  localparam int KEY_DEPTH = 64;
  localparam int KEY_AW    = $clog2(KEY_DEPTH);   // matches the 6-bit key_index field
  localparam int CNT_W     = 7;                   // key_count register width

  // Number formats
  localparam int VAL_W     = 32;                  // Q16.16
  localparam int FRAC_W    = 16;                  // Q0.16 blend fraction
  localparam int NUM_COMP  = 3;
  localparam int COMP_W    = 2;
  localparam int DIV_STEPS = FRAC_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);
  localparam int PROD_W    = (VAL_W + 1) + (FRAC_W + 1);

  localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

  typedef logic [NUM_COMP-1:0][VAL_W-1:0] vec_t;

  typedef enum logic [1:0] {
    CASE_INTERP = 2'd0,
    CASE_FIRST  = 2'd1,
    CASE_LAST   = 2'd2
  } sample_case_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } ctrl_state_e;

  // Controller -> datapath
  typedef struct packed {
    logic         write;     // store the keyframe on the request channel
    logic         start;     // latch query and clamped count, point at key 0
    logic         advance;   // step to the next key, keep the previous one
    logic         take_key;  // result is the key under the pointer
    sample_case_e kase;      // case tag for take_key
    logic         div_load;  // segment found, set up the fraction divide
    logic         div_step;  // one quotient bit
    logic         mul;       // (b - a) * frac for the current component
    logic         acc;       // a + product, next component
    logic         emit;      // move the result into the output register
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic n_one;       // only one key
    logic q_le_key;    // query <= time under the pointer
    logic in_seg;      // previous time <= query <= time under the pointer
    logic at_last;     // pointer on the last valid key
    logic div_done;
    logic last_comp;
    logic out_busy;    // output register full and not taken this cycle
  } dp_status_t;

endpackage

`default_nettype wire

// File: hdl/kfls_req_if.sv
// ============================================================================
// kfls_req_if
// Request channel: key writes and sample queries.
// ============================================================================
`default_nettype none

interface kfls_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [5:0]  key_index;
  logic [31:0] key_time;
  logic [31:0] key_x;
  logic [31:0] key_y;
  logic [31:0] key_z;
  logic [31:0] query_time;

  modport source (
    output valid, op, key_index, key_time, key_x, key_y, key_z, query_time,
    input  ready
  );
  modport sink (
    input  valid, op, key_index, key_time, key_x, key_y, key_z, query_time,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/kfls_rsp_if.sv
// ============================================================================
// kfls_rsp_if
// Response channel: one sampled vector per sample query.
// ============================================================================
`default_nettype none

interface kfls_rsp_if;
  logic                  valid;
  logic                  ready;
  logic [31:0]           out_x;
  logic [31:0]           out_y;
  logic [31:0]           out_z;
  kfls_pkg::sample_case_e sample_case;

  modport source (
    output valid, out_x, out_y, out_z, sample_case,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, sample_case,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/kfls_ctrl.sv
// ============================================================================
// kfls_ctrl
// Sequencer: key search, fraction divide, per-component blend, result hand-off.
// ============================================================================
`default_nettype none

module kfls_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               req_valid_i,
  input  wire logic               req_op_i,
  output logic                    req_ready_o,
  input  wire kfls_pkg::dp_status_t sts_i,
  output kfls_pkg::ctrl_cmd_t     cmd_o
);
  import kfls_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    cmd_o.kase  = CASE_FIRST;
    req_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_op_i) begin
            cmd_o.start = 1'b1;
            state_d     = ST_FIRST;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_FIRST: begin
        if (sts_i.n_one || sts_i.q_le_key) begin
          cmd_o.take_key = 1'b1;
          cmd_o.kase     = CASE_FIRST;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (sts_i.in_seg) begin
          cmd_o.div_load = 1'b1;
          state_d        = ST_DIV;
        end else if (sts_i.at_last) begin
          cmd_o.take_key = 1'b1;
          cmd_o.kase     = CASE_LAST;
          state_d        = ST_EMIT;
        end else begin
          cmd_o.advance = 1'b1;
        end
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last_comp ? ST_EMIT : ST_MUL;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/kfls_dp.sv
// ============================================================================
// kfls_dp
// Datapath: key tables, search registers, restoring divider, shared blender,
// configuration register and output register.
// ============================================================================
`default_nettype none

module kfls_dp (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [6:0]            cfg_wdata_i,
  input  wire logic [5:0]            key_index_i,
  input  wire logic [31:0]           key_time_i,
  input  wire kfls_pkg::vec_t        key_val_i,
  input  wire logic [31:0]           query_time_i,
  input  wire kfls_pkg::ctrl_cmd_t   cmd_i,
  output kfls_pkg::dp_status_t       sts_o,
  kfls_rsp_if.source                 rsp_o
);
  import kfls_pkg::*;

  // Key tables; read data registered, address follows the next pointer so
  // trd_q/vrd_q always hold the entry under idx_q.
  logic [VAL_W-1:0] t_mem [KEY_DEPTH];
  vec_t             v_mem [KEY_DEPTH];

  logic [CNT_W-1:0]  key_count_q;
  logic [CNT_W-1:0]  n_q;
  logic [KEY_AW-1:0] idx_q, idx_d;
  logic [VAL_W-1:0]  q_q;
  logic [VAL_W-1:0]  tprev_q;
  logic [VAL_W-1:0]  trd_q;
  vec_t              vrd_q;
  vec_t              a_q, b_q;
  vec_t              res_q;
  sample_case_e      res_case_q;

  logic [VAL_W-1:0]  span_q;
  logic [VAL_W-1:0]  rem_q;
  logic [FRAC_W-1:0] quo_q;
  logic [DIV_CW-1:0] div_cnt_q;

  logic [COMP_W-1:0]        comp_q;
  logic signed [PROD_W-1:0] prod_q;

  logic                     out_valid_q;
  vec_t                     out_q;
  sample_case_e             out_case_q;

  // ---- derived values ----
  logic [VAL_W-1:0]         num_w, span_w;
  logic [VAL_W:0]           rem2_w;
  logic                     ge_w;
  logic [CNT_W-1:0]         n_clamp_w;
  logic signed [VAL_W:0]    diff_w;
  logic [VAL_W-1:0]         a_sel_w, b_sel_w;

  assign num_w  = q_q - tprev_q;
  assign span_w = trd_q - tprev_q;
  assign rem2_w = {rem_q, 1'b0};
  assign ge_w   = rem2_w >= {1'b0, span_q};

  assign a_sel_w = a_q[comp_q];
  assign b_sel_w = b_q[comp_q];
  assign diff_w  = $signed({b_sel_w[VAL_W-1], b_sel_w}) - $signed({a_sel_w[VAL_W-1], a_sel_w});

  always_comb begin
    priority if (key_count_q == '0) begin
      n_clamp_w = CNT_W'(1);
    end else if (key_count_q > CNT_W'(KEY_DEPTH)) begin
      n_clamp_w = CNT_W'(KEY_DEPTH);
    end else begin
      n_clamp_w = key_count_q;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = '0;
    end else if (cmd_i.advance) begin
      idx_d = idx_q + KEY_AW'(1);
    end
  end

  // ---- tables (every 6-bit index is a valid slot) ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      t_mem[key_index_i] <= key_time_i;
      v_mem[key_index_i] <= key_val_i;
    end
    trd_q <= t_mem[idx_d];
    vrd_q <= v_mem[idx_d];
  end

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_count_q <= CNT_W'(1);
      idx_q       <= '0;
      div_cnt_q   <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
      idx_q <= idx_d;

      if (cmd_i.div_load) begin
        div_cnt_q <= (span_w == '0 || num_w == span_w) ? DIV_CW'(DIV_STEPS) : '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + DIV_CW'(1);
      end

      if (cmd_i.div_load) begin
        comp_q <= '0;
      end else if (cmd_i.acc) begin
        comp_q <= comp_q + COMP_W'(1);
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      q_q <= query_time_i;
      n_q <= n_clamp_w;
    end
    if (cmd_i.advance) begin
      tprev_q <= trd_q;
      a_q     <= vrd_q;
    end
    if (cmd_i.take_key) begin
      res_q      <= vrd_q;
      res_case_q <= cmd_i.kase;
    end
    if (cmd_i.div_load) begin
      b_q        <= vrd_q;
      span_q     <= span_w;
      rem_q      <= num_w;
      res_case_q <= CASE_INTERP;
      // zero-length segment -> 0, query on the segment end -> saturated
      quo_q      <= (span_w == '0) ? '0 : ((num_w == span_w) ? FRAC_MAX : '0);
    end else if (cmd_i.div_step) begin
      rem_q <= ge_w ? VAL_W'(rem2_w - {1'b0, span_q}) : rem2_w[VAL_W-1:0];
      quo_q <= {quo_q[FRAC_W-2:0], ge_w};
    end
    if (cmd_i.mul) begin
      prod_q <= diff_w * $signed({1'b0, quo_q});
    end
    if (cmd_i.acc) begin
      // floor((b - a) * f / 2^16) is an arithmetic shift
      res_q[comp_q] <= a_sel_w + prod_q[FRAC_W +: VAL_W];
    end
    if (cmd_i.emit) begin
      out_q      <= res_q;
      out_case_q <= res_case_q;
    end
  end

  // ---- status ----
  assign sts_o.n_one     = (n_q == CNT_W'(1));
  assign sts_o.q_le_key  = (q_q <= trd_q);
  assign sts_o.in_seg    = (tprev_q <= q_q) && (q_q <= trd_q);
  assign sts_o.at_last   = ({1'b0, idx_q} == (n_q - CNT_W'(1)));
  assign sts_o.div_done  = (div_cnt_q == DIV_CW'(DIV_STEPS));
  assign sts_o.last_comp = (comp_q == COMP_W'(NUM_COMP - 1));
  assign sts_o.out_busy  = out_valid_q && !rsp_o.ready;

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_x       = out_q[0];
  assign rsp_o.out_y       = out_q[1];
  assign rsp_o.out_z       = out_q[2];
  assign rsp_o.sample_case = out_case_q;

  // ---- checks ----
  a_step_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (({1'b0, idx_q} + CNT_W'(1)) < n_q))
    else $error("key pointer stepped past the last valid key");

  a_div_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_cnt_q <= DIV_CW'(DIV_STEPS))
    else $error("divider step count overran");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !rsp_o.ready))
    else $error("result emitted over a pending one");

  a_comp_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.mul || cmd_i.acc) |-> (comp_q < COMP_W'(NUM_COMP)))
    else $error("component index out of range");

endmodule

`default_nettype wire

// File: hdl/keyframe_linear_sampler_top.sv
// ============================================================================
// keyframe_linear_sampler_top
// Piecewise-linear keyframe interpolator over a 64-entry Q16.16 key table.
// ============================================================================
// Usage:
//  - req_i carries key writes (op = 0) and sample queries (op = 1); a transfer
//    happens when valid and ready are both high. rsp_o returns one vector per
//    sample query, none per key write.
//  - cfg_we_i/cfg_wdata_i set key_count (reset value 1); write it only while
//    the block is idle. Zero acts as one key, above 64 as 64.
//  - A key write is taken while the block is idle and stores straight into the table.
//  - A sample walks the keys one per cycle (registered table read), then runs
//    a 16-step restoring divide for the Q0.16 fraction (skipped on a zero-length
//    segment or a query on the segment end) and a shared multiplier that takes
//    x, y, z in turn, with a multiply step and then an add step for each.
//  - One sample is in flight at a time; the block is ready for the next request
//    in the same cycle that the result turns valid.
//  - The result sits in an output register. The block takes the next request
//    while it waits; a finished sample is held until that register frees,
//    so a stalled receiver adds its stall cycles to the latency.
//  - Reset (rst_ni low, asynchronous) empties the output register, sets
//    key_count to 1 and returns the sequencer to idle. Table contents are not
//    cleared: sample only keys that were written.
// ============================================================================
`default_nettype none

module keyframe_linear_sampler_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [6:0] cfg_wdata_i,
  kfls_req_if.sink        req_i,
  kfls_rsp_if.source      rsp_o
);
  import kfls_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       req_ready;
  vec_t       key_val;

  assign req_i.ready = req_ready;

  // pack the key vector x, y, z as components 0, 1, 2
  assign key_val = {req_i.key_z, req_i.key_y, req_i.key_x};

  kfls_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.op),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kfls_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .key_index_i  (req_i.key_index),
    .key_time_i   (req_i.key_time),
    .key_val_i    (key_val),
    .query_time_i (req_i.query_time),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

endmodule

`default_nettype wire

// File: bench/keyframe_linear_sampler_top_tb.sv
// ============================================================================
// keyframe_linear_sampler_top_tb
// Self-checking bench for the keyframe linear sampler. Key writes and sample
// queries go in over the request channel; a scoreboard keeps its own copy of
// the key table and the key count, predicts each sampled vector and checks
// the response channel against it in order. A directed opening is followed
// by random phases, each with its own key count, key table and pacing mix.
// ============================================================================
`default_nettype none

module keyframe_linear_sampler_top_tb;
  import kfls_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int ITEM_TARGET    = 950;   // request transfers before wrap-up
  localparam int SETTLE_CYCLES  = 100;   // worst-case sample latency plus margin
  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any transfer

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  typedef struct packed {
    logic              op;
    logic [KEY_AW-1:0] key_index;
    logic [VAL_W-1:0]  key_time;
    logic [VAL_W-1:0]  key_x;
    logic [VAL_W-1:0]  key_y;
    logic [VAL_W-1:0]  key_z;
    logic [VAL_W-1:0]  query_time;
  } request_t;

  typedef struct packed {
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
    sample_case_e     kase;
  } sample_t;

  // Shadow key table plus in-order queue of predicted vectors.
  class keyframe_scoreboard;
    localparam int REPORT_LIMIT = 10;

    logic [VAL_W-1:0] time_tab [KEY_DEPTH];
    vec_t             value_tab [KEY_DEPTH];
    int unsigned      key_count;
    sample_t          pending_vectors [$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
      key_count  = 1;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_key_count(logic [CNT_W-1:0] value);
      key_count = value;
    endfunction

    function int unsigned pending();
      return pending_vectors.size();
    endfunction

    function sample_t interpolate_at(logic [VAL_W-1:0] q);
      sample_t           s;
      vec_t              mixed;
      int                n;
      int                seg;
      int                pick;
      logic [VAL_W-1:0]  span;
      logic [47:0]       quo;
      logic [FRAC_W-1:0] frac;
      longint            a;
      longint            b;
      longint            prod;
      longint            sum;
      n    = (key_count == 0) ? 1 : ((key_count > KEY_DEPTH) ? KEY_DEPTH : key_count);
      seg  = -1;
      pick = 0;
      frac = '0;
      s.kase = CASE_FIRST;
      if (n > 1 && q > time_tab[0]) begin
        // first segment that encloses the query wins, even if unsorted
        for (int i = 0; i + 1 < n; i++) begin
          if (time_tab[i] <= q && q <= time_tab[i+1]) begin
            seg = i;
            break;
          end
        end
        if (seg < 0) begin
          pick   = n - 1;
          s.kase = CASE_LAST;
        end
      end
      if (seg < 0) begin
        s.x = value_tab[pick][0];
        s.y = value_tab[pick][1];
        s.z = value_tab[pick][2];
        return s;
      end
      span = time_tab[seg+1] - time_tab[seg];
      if (span != 0) begin
        quo  = {q - time_tab[seg], 16'h0000} / {16'h0000, span};
        frac = (quo > FRAC_MAX) ? FRAC_MAX : quo[FRAC_W-1:0];
      end
      for (int c = 0; c < NUM_COMP; c++) begin
        a    = $signed(value_tab[seg][c]);
        b    = $signed(value_tab[seg+1][c]);
        prod = (b - a) * longint'(frac);
        sum  = a + (prod >>> FRAC_W);   // floor, also for negative steps
        mixed[c] = sum[VAL_W-1:0];
      end
      s.x    = mixed[0];
      s.y    = mixed[1];
      s.z    = mixed[2];
      s.kase = CASE_INTERP;
      return s;
    endfunction

    function void note_request(request_t r);
      if (r.op == OP_WRITE) begin
        time_tab[r.key_index]  = r.key_time;
        value_tab[r.key_index] = {r.key_z, r.key_y, r.key_x};
      end else begin
        pending_vectors.push_back(interpolate_at(r.query_time));
      end
    endfunction

    function void check_result(sample_t got);
      sample_t want;
      checked++;
      if (pending_vectors.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: x=%h y=%h z=%h case=%0d",
                   got.x, got.y, got.z, got.kase);
        return;
      end
      want = pending_vectors.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
          got.kase !== want.kase) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: expected x=%h y=%h z=%h case=%0d, got x=%h y=%h z=%h case=%0d",
                   want.x, want.y, want.z, want.kase, got.x, got.y, got.z, got.kase);
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  kfls_req_if req_if ();
  kfls_rsp_if rsp_if ();

  keyframe_linear_sampler_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_if),
    .rsp_o       (rsp_if)
  );

  keyframe_scoreboard board;

  // Stimulus-side copy of key times, used only to aim queries at segments.
  logic [VAL_W-1:0] stim_times [KEY_DEPTH];

  int unsigned send_idle_pct  = 0;   // chance the sender sits out a cycle
  int unsigned recv_stall_pct = 0;   // chance the receiver drops ready
  int unsigned items_sent     = 0;
  int unsigned cfg_writes     = 0;
  int unsigned phases         = 0;
  int unsigned quiet_cycles   = 0;

  always #(CLK_PERIOD/2) clk_i = ~clk_i;

  // Receiver backpressure, redrawn every falling edge.
  always @(negedge clk_i) begin
    rsp_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Both channels are observed at the rising edge. Every request transfer
  // updates the shadow table or queues a prediction; every response transfer
  // is checked against the oldest prediction. The watchdog trips when no
  // transfer happens on either side for too long.
  always @(posedge clk_i) begin : observe
    request_t seen;
    sample_t  got;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        seen.op         = req_if.op;
        seen.key_index  = req_if.key_index;
        seen.key_time   = req_if.key_time;
        seen.key_x      = req_if.key_x;
        seen.key_y      = req_if.key_y;
        seen.key_z      = req_if.key_z;
        seen.query_time = req_if.query_time;
        board.note_request(seen);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        got.x    = rsp_if.out_x;
        got.y    = rsp_if.out_y;
        got.z    = rsp_if.out_z;
        got.kase = rsp_if.sample_case;
        board.check_result(got);
      end
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("keyframe_linear_sampler_top_tb: FAIL");
        $finish;
      end
    end
  end

  // Uniform pick in [lo, hi], full 32-bit range allowed.
  function automatic logic [VAL_W-1:0] rand_span(logic [VAL_W-1:0] lo, logic [VAL_W-1:0] hi);
    longint unsigned width;
    if (hi < lo)
      return lo;
    width = {32'h0, hi} - {32'h0, lo} + 64'd1;
    return lo + 32'({$urandom, $urandom} % width);
  endfunction

  // Key component values lean on the extremes so b - a can span 2^32.
  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return rand_span(32'hFFFE_0000, 32'hFFFF_FFFF);
      3:       return rand_span(32'h0, 32'h0002_0000);
      default: return $urandom;
    endcase
  endfunction

  // Query aimed at the current table: inside a segment, on or next to a
  // key, before the first key, past the last one, or anywhere.
  function automatic logic [VAL_W-1:0] pick_query(int n);
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [VAL_W-1:0] ta;
    logic [VAL_W-1:0] tb;
    int               k;
    lo = stim_times[0];
    hi = stim_times[0];
    for (int i = 1; i < n; i++) begin
      if (stim_times[i] < lo) lo = stim_times[i];
      if (stim_times[i] > hi) hi = stim_times[i];
    end
    k  = $urandom_range(n - 1);
    ta = stim_times[k];
    tb = stim_times[(k + 1 < n) ? k + 1 : k];
    case ($urandom_range(9))
      0, 1:    return rand_span(lo, hi);
      2, 3:    return (ta <= tb) ? rand_span(ta, tb) : rand_span(tb, ta);
      4:       return ta;
      5:       return $urandom_range(1) ? ta + 32'd1 : ta - 32'd1;
      6:       return rand_span(32'h0, stim_times[0]);
      7:       return rand_span(hi, 32'hFFFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  // One request transfer. Valid is left high on return so back-to-back
  // items go out without a gap; any pause lowers it first.
  task automatic send_request(input request_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.op         = r.op;
    req_if.key_index  = r.key_index;
    req_if.key_time   = r.key_time;
    req_if.key_x      = r.key_x;
    req_if.key_y      = r.key_y;
    req_if.key_z      = r.key_z;
    req_if.query_time = r.query_time;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic store_key(input logic [KEY_AW-1:0] idx, input logic [VAL_W-1:0] t,
                           input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                           input logic [VAL_W-1:0] z);
    request_t r;
    r.op         = OP_WRITE;
    r.key_index  = idx;
    r.key_time   = t;
    r.key_x      = x;
    r.key_y      = y;
    r.key_z      = z;
    r.query_time = $urandom;   // don't-care on a key write
    stim_times[idx] = t;
    send_request(r);
  endtask

  task automatic sample_at(input logic [VAL_W-1:0] q);
    request_t r;
    r.op         = OP_SAMPLE;
    r.key_index  = KEY_AW'($urandom);   // key fields are don't-care on a sample
    r.key_time   = $urandom;
    r.key_x      = $urandom;
    r.key_y      = $urandom;
    r.key_z      = $urandom;
    r.query_time = q;
    send_request(r);
  endtask

  // Sender holds off until every predicted vector has come back.
  task automatic drain_results();
    req_if.valid = 1'b0;
    while (board.pending() != 0) @(negedge clk_i);
  endtask

  // key_count is only touched while the sampler is idle.
  task automatic write_key_count(input logic [CNT_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_wdata_i = value;
    cfg_we_i    = 1'b1;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    board.set_key_count(value);
    cfg_writes++;
  endtask

  // Fill slots 0..n-1: mostly ascending times (dense with repeats, or
  // spread over the whole range), sometimes fully scrambled.
  task automatic fill_keys(input int n);
    int              style;
    longint unsigned t;
    longint unsigned step;
    style = $urandom_range(99);
    t = (style < 60) ? $urandom_range(32'h0004_0000) : rand_span(32'h0, 32'h7FFF_FFFF);
    for (int i = 0; i < n; i++) begin
      if (style < 15) begin
        t = $urandom;
      end else if (i > 0) begin
        if (style < 60)
          step = ($urandom_range(99) < 15) ? 0 : $urandom_range(32'h0003_0000, 1);
        else
          step = rand_span(32'h0, 32'((64'hFFFF_FFFF - t) / (n - i)));
        t = (t + step > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : t + step;
      end
      store_key(KEY_AW'(i), t[VAL_W-1:0], random_value(), random_value(), random_value());
    end
  endtask

  // One random phase: new key count, new table, a burst of queries with
  // some stray key writes mixed in. Pacing rotates through four mixes.
  task automatic run_phase(input logic [CNT_W-1:0] count_val);
    int n;
    int queries;
    n = (count_val == 0) ? 1 : ((count_val > KEY_DEPTH) ? KEY_DEPTH : count_val);
    write_key_count(count_val);
    case (phases % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
      default: begin send_idle_pct = 20; recv_stall_pct = 20; end
    endcase
    fill_keys(n);
    queries = $urandom_range(40, 20);
    for (int s = 0; s < queries; s++) begin
      if (phases % 3 == 1 && s == queries / 2)
        drain_results();
      if ($urandom_range(99) < 12)
        store_key(KEY_AW'($urandom), $urandom, random_value(), random_value(),
                  random_value());
      else
        sample_at(pick_query(n));
    end
    phases++;
  endtask

  initial begin
    logic [CNT_W-1:0] next_count;
    int               roll;
    board             = new();
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_WRITE;
    req_if.key_index  = '0;
    req_if.key_time   = '0;
    req_if.key_x      = '0;
    req_if.key_y      = '0;
    req_if.key_z      = '0;
    req_if.query_time = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed opening. Reset key count is one: only slot 0 is ever used.
    store_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
    sample_at(32'h0000_0000);
    sample_at(32'hFFFF_FFFF);
    // A count of zero behaves as one key.
    write_key_count(0);
    sample_at(32'h1234_5678);
    // Five keys: extreme swings in value, a pair of equal times, and a last
    // key earlier than the one before it. The top slot is written too.
    store_key(1, 32'h0003_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    store_key(2, 32'h0003_0000, 32'h0000_0001, 32'hFFFF_0000, 32'h0001_0000);
    store_key(3, 32'h8000_0000, 32'h0123_4567, 32'hFEDC_BA98, 32'h0000_0000);
    store_key(4, 32'h7FFF_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF);
    store_key(63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_key_count(5);
    sample_at(32'h0000_8000);   // before the first key
    sample_at(32'h0001_0000);   // exactly on the first key
    sample_at(32'h0002_0000);   // middle of a full-swing segment
    sample_at(32'h0003_0000);   // segment end, fraction saturates
    sample_at(32'h4000_0000);   // long segment
    sample_at(32'h7FFF_8000);   // inside the long segment, near its end
    sample_at(32'h8000_0000);   // end of the long segment
    sample_at(32'hFFFF_FFFF);   // nothing encloses it: last key

    // Random phases; the first two use a full table, via 64 and via 127.
    while (items_sent < ITEM_TARGET) begin
      roll = $urandom_range(99);
      if (phases == 0)
        next_count = 7'd64;
      else if (phases == 1)
        next_count = 7'd127;
      else if (roll < 8)
        next_count = 7'd0;
      else if (roll < 16)
        next_count = 7'd1;
      else if (roll < 21)
        next_count = CNT_W'($urandom_range(126, 65));
      else
        next_count = CNT_W'($urandom_range(12, 2));
      run_phase(next_count);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk_i);

    $display("covered %0d request transfers, %0d sampled vectors checked, %0d key-count writes",
             items_sent, board.checked, cfg_writes);
    $display("tables: sorted, equal-time and out-of-order; pacing: free, idle sender, stalled sink, both");
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("keyframe_linear_sampler_top_tb: PASS");
    end else begin
      $display("%0d mismatches, %0d vectors never returned", board.mismatches, board.pending());
      $display("keyframe_linear_sampler_top_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
